FILE: rtl/ffgc_pkg.sv
`default_nettype none

package ffgc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VTX_W        = 10;
  localparam int COL_W        = 11;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int WORD_W       = 32;
  localparam int WORDS        = MAX_VERTICES / WORD_W;
  localparam int WIDX_W       = $clog2(WORDS);
  localparam int BIDX_W       = $clog2(WORD_W);

  typedef struct packed {
    logic             first_of_graph;
    logic [VTX_W-1:0] target_vertex;
    logic [VTX_W-1:0] neighbour;
    logic             has_neighbour;
    logic             last_of_vertex;
  } item_t;

  typedef struct packed {
    logic [VTX_W-1:0] coloured_vertex;
    logic [COL_W-1:0] colour;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  data;
  } colour_wr_t;

  typedef struct packed {
    logic              go;
    logic              clear;
    logic [ADDR_W-1:0] rd_idx;
    logic              s2_valid;
    logic              s2_mark;
    logic [ADDR_W-1:0] s2_idx;
    logic              s2_last;
  } mark_ctl_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/ffgc_colour_store.sv
`default_nettype none

module ffgc_colour_store (
  input  wire                              clk,
  input  wire                              rst,
  input  wire [ffgc_pkg::ADDR_W-1:0]       rd_addr,
  input  wire ffgc_pkg::colour_wr_t        wr,
  output logic [ffgc_pkg::COL_W-1:0]       rd_colour
);
  import ffgc_pkg::*;

  logic [COL_W-1:0]  mem [MAX_VERTICES];
  logic [COL_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              wr_last_en;
  logic [ADDR_W-1:0] wr_last_addr;
  logic [COL_W-1:0]  wr_last_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data      <= mem[rd_addr];
    rd_addr_q    <= rd_addr;
    wr_last_addr <= wr.addr;
    wr_last_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_last_en <= 1'b0;
    end else begin
      wr_last_en <= wr.en;
    end
  end

  // forward a write that landed on the same edge as the read
  assign rd_colour = (wr_last_en && (wr_last_addr == rd_addr_q)) ? wr_last_data : rd_data;

endmodule

`default_nettype wire

FILE: rtl/ffgc_mark_unit.sv
`default_nettype none

module ffgc_mark_unit (
  input  wire                        clk,
  input  wire                        rst,
  input  wire ffgc_pkg::mark_ctl_t   ctl,
  output logic [ffgc_pkg::COL_W-1:0] colour
);
  import ffgc_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  word_valid;
  logic [WORDS-1:0]  word_full;
  logic [WORDS-1:0]  valid_upd;
  logic [WORDS-1:0]  full_upd;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] upd;
  logic              fw_valid;
  logic [WIDX_W-1:0] fw_widx;
  logic [WORD_W-1:0] fw_data;
  logic [WIDX_W-1:0] widx;
  logic [BIDX_W-1:0] bidx;
  logic [WIDX_W-1:0] sel;
  logic              setting;
  logic [WIDX_W-1:0] s3_sel;
  logic              s3_sel_valid;
  logic              s3_all_full;
  logic              s3_fwd;
  logic [WORD_W-1:0] s3_rd_word;
  logic [WORD_W-1:0] s3_fwd_word;
  logic [WORD_W-1:0] s3_word;
  logic [BIDX_W-1:0] zbit;

  assign widx    = ctl.s2_idx[ADDR_W-1:BIDX_W];
  assign bidx    = ctl.s2_idx[BIDX_W-1:0];
  assign setting = ctl.s2_valid && ctl.s2_mark;

  always_comb begin
    base = word_valid[widx] ? rd_word : '0;
    if (fw_valid && (fw_widx == widx)) begin
      base = fw_data;
    end
    upd       = base | (WORD_W'(1) << bidx);
    valid_upd = word_valid;
    full_upd  = word_full;
    if (setting) begin
      valid_upd[widx] = 1'b1;
      full_upd[widx]  = &upd;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_upd[i]) begin
        sel = WIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (setting) begin
        mem[widx] <= upd;
      end
      rd_word      <= mem[ctl.rd_idx[ADDR_W-1:BIDX_W]];
      s3_rd_word   <= mem[sel];
      s3_sel       <= sel;
      s3_sel_valid <= valid_upd[sel];
      s3_all_full  <= &full_upd;
      s3_fwd       <= setting && (sel == widx);
      s3_fwd_word  <= upd;
      fw_widx      <= widx;
      fw_data      <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      word_full  <= '0;
      fw_valid   <= 1'b0;
    end else if (ctl.clear) begin
      word_valid <= '0;
      word_full  <= '0;
      fw_valid   <= 1'b0;
    end else if (ctl.go) begin
      if (ctl.s2_valid && ctl.s2_last) begin
        word_valid <= '0;
        word_full  <= '0;
        fw_valid   <= 1'b0;
      end else begin
        word_valid <= valid_upd;
        word_full  <= full_upd;
        fw_valid   <= setting;
      end
    end
  end

  always_comb begin
    s3_word = s3_sel_valid ? s3_rd_word : '0;
    if (s3_fwd) begin
      s3_word = s3_fwd_word;
    end
    zbit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!s3_word[i]) begin
        zbit = BIDX_W'(i);
      end
    end
    if (s3_all_full) begin
      colour = COL_W'(MAX_VERTICES);
    end else begin
      colour = COL_W'({s3_sel, zbit}) + COL_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/first_fit_graph_coloring.sv
// The last entry word of a vertex passes s1, s2 and s3; its result word is registered from s3.
// Throughput: one entry word per cycle while item_stall is low; an entry that names the vertex
//   finished just before is held in s1 until that colour reaches the selection stage.
// Reset sweeps the 1024-entry colour store, one entry a cycle, with item_stall high.
// A first_of_graph word waits for the pipeline to drain and runs the same sweep,
//   unless no word was taken since the last sweep.
`default_nettype none

module first_fit_graph_coloring (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  wire ffgc_pkg::item_t item,
  output logic                 result_valid,
  input  wire                  result_stall,
  output ffgc_pkg::result_t    result
);
  import ffgc_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] clr_cnt_next;
  logic              clr_done;
  logic              clr_done_next;
  logic              clearing;

  logic              s1_valid;
  item_t             s1;
  logic              s2_valid;
  logic              s2_last;
  logic              s2_mark;
  logic [VTX_W-1:0]  s2_target;
  logic [ADDR_W-1:0] s2_idx;
  logic              s3_valid;
  logic              s3_last;
  logic [VTX_W-1:0]  s3_target;

  logic              go;
  logic              ilock;
  logic              s1_adv;
  logic              accept;
  logic              pipe_empty;
  logic              s3_store;
  logic              s1_mark;
  logic [ADDR_W-1:0] s1_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  rd_colour;
  logic [COL_W-1:0]  nb_colour;
  logic [COL_W-1:0]  s3_colour;
  colour_wr_t        cwr;
  mark_ctl_t         mctl;

  assign go         = !(s3_valid && s3_last && result_valid && result_stall);
  assign ilock      = s1_valid && s2_valid && s2_last && s1.has_neighbour &&
                      (s1.neighbour == s2_target);
  assign s1_adv     = go && !ilock;
  assign pipe_empty = !s1_valid && !s2_valid && !s3_valid;
  assign item_stall = (state != ST_RUN) || (item.first_of_graph && !clr_done) ||
                      (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;
  assign s3_store   = int'(s3_target) < MAX_VERTICES;
  assign rd_addr    = (s1_valid && !s1_adv) ? ADDR_W'(s1.neighbour) : ADDR_W'(item.neighbour);

  always_comb begin
    nb_colour = rd_colour;
    if (s3_valid && s3_last && s3_store && (s3_target == s1.neighbour)) begin
      nb_colour = s3_colour;
    end
  end

  assign s1_mark = s1.has_neighbour && (s1.neighbour != s1.target_vertex) &&
                   (int'(s1.neighbour) < MAX_VERTICES) && (nb_colour != '0) &&
                   (nb_colour <= COL_W'(MAX_VERTICES));
  assign s1_idx  = ADDR_W'(nb_colour - COL_W'(1));

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    clr_done_next = clr_done;
    clearing      = 1'b0;
    case (state)
      ST_CLEAR: begin
        clearing     = 1'b1;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(MAX_VERTICES - 1)) begin
          state_next    = ST_RUN;
          clr_done_next = 1'b1;
        end
      end
      ST_RUN: begin
        if (accept) begin
          clr_done_next = 1'b0;
        end else if (item_valid && item.first_of_graph && !clr_done && pipe_empty) begin
          state_next   = ST_CLEAR;
          clr_cnt_next = '0;
        end
      end
      default: begin
        state_next   = ST_CLEAR;
        clr_cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      clr_done <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      clr_done <= clr_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        s2_valid <= s1_valid && !ilock;
        s3_valid <= s2_valid;
      end
      if (go && s3_valid && s3_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
    if (go) begin
      s2_target <= s1.target_vertex;
      s2_last   <= s1.last_of_vertex;
      s2_mark   <= s1_mark;
      s2_idx    <= s1_idx;
      s3_target <= s2_target;
      s3_last   <= s2_last;
    end
    if (go && s3_valid && s3_last) begin
      result.coloured_vertex <= s3_target;
      result.colour          <= s3_colour;
    end
  end

  always_comb begin
    cwr.en   = clearing || (go && s3_valid && s3_last && s3_store);
    cwr.addr = clearing ? clr_cnt : ADDR_W'(s3_target);
    cwr.data = clearing ? '0 : s3_colour;
  end

  always_comb begin
    mctl.go       = go;
    mctl.clear    = clearing;
    mctl.rd_idx   = s1_idx;
    mctl.s2_valid = s2_valid;
    mctl.s2_mark  = s2_mark;
    mctl.s2_idx   = s2_idx;
    mctl.s2_last  = s2_last;
  end

  ffgc_colour_store u_colour_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .wr        (cwr),
    .rd_colour (rd_colour)
  );

  ffgc_mark_unit u_mark_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mctl),
    .colour (s3_colour)
  );

  a_clear_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> pipe_empty)
    else $error("colour store sweep with words in flight");

  a_colour_range: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_last) |-> ((s3_colour != '0) && (s3_colour <= COL_W'(MAX_VERTICES))))
    else $error("selected colour out of range");

  a_ilock_hold: assert property (@(posedge clk) disable iff (rst)
    ilock |=> (s1_valid && $stable(s1)))
    else $error("interlocked entry word not held");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    clr_done |-> pipe_empty)
    else $error("sweep marked done with words in flight");

endmodule

`default_nettype wire
